FILE: rtl/core/simd_parallel_add_subtract_unit_defines.svh
// ----------------------------------------------------------------------------
// SIMD parallel add/subtract unit: assertion macros
// Concurrent check macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SIMD_PARALLEL_ADD_SUBTRACT_UNIT_DEFINES_SVH
`define SIMD_PARALLEL_ADD_SUBTRACT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SPAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define SPAS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPAS_ASSERT(lbl, prop, msg)
`define SPAS_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/core/spas_pkg.sv
// ----------------------------------------------------------------------------
// spas_pkg
// Shared codes, types and lane arithmetic for the SIMD add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spas_pkg;

    // fixed-bit patterns of the encodings
    localparam logic [15:0] SelMask1 = 16'hfff0;
    localparam logic [15:0] SelVal1  = 16'hfaa0;
    localparam logic [15:0] SelMask2 = 16'hf0f0;
    localparam logic [15:0] SelVal2  = 16'hf080;
    localparam logic [15:0] ParMask1 = 16'hff80;
    localparam logic [15:0] ParVal1  = 16'hfa80;
    localparam logic [15:0] ParMask2 = 16'hf080;
    localparam logic [15:0] ParVal2  = 16'hf000;

    // lane operation codes
    localparam logic [2:0] OP_ADD8  = 3'd0;
    localparam logic [2:0] OP_ADD16 = 3'd1;
    localparam logic [2:0] OP_ASX   = 3'd2;
    localparam logic [2:0] OP_SUB8  = 3'd4;
    localparam logic [2:0] OP_SUB16 = 3'd5;
    localparam logic [2:0] OP_SAX   = 3'd6;

    // mode kind, low two bits of mode (bit 2 = unsigned)
    localparam logic [1:0] MK_PLAIN  = 2'd0;
    localparam logic [1:0] MK_SAT    = 2'd1;
    localparam logic [1:0] MK_HALVE  = 2'd2;
    localparam logic [1:0] MK_UNUSED = 2'd3;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    typedef struct packed {
        logic       sel;
        logic       par;
        logic       byte_mode;
        logic       swap;
        logic       sub_lo;
        logic       sub_hi;
        logic       uns;
        logic       sat;
        logic       halve;
        logic [3:0] rd;
    } ctrl_t;

    typedef struct packed {
        logic [15:0] res;
        logic [1:0]  ge;
    } lane_out_t;

    typedef struct packed {
        logic        recognized;
        logic [31:0] word;
        logic [3:0]  dest;
        logic        ge_written;
        logic [3:0]  ge_value;
    } result_t;

    // {pass, result} for one byte
    function automatic logic [8:0] byte_arith(input logic [7:0] a, input logic [7:0] b,
                                              input logic sub, input logic uns,
                                              input logic sat, input logic halve);
        logic signed [9:0] ax;
        logic signed [9:0] bx;
        logic signed [9:0] x;
        logic [7:0]        r;
        logic              pass;
        ax = uns ? $signed({2'b00, a}) : $signed({{2{a[7]}}, a});
        bx = uns ? $signed({2'b00, b}) : $signed({{2{b[7]}}, b});
        x  = sub ? (ax - bx) : (ax + bx);
        if (sat) begin
            if (uns) begin
                r = x[9] ? 8'h00 : (x[8] ? 8'hff : x[7:0]);
            end
            else begin
                r = (x < -10'sd128) ? 8'h80 : ((x > 10'sd127) ? 8'h7f : x[7:0]);
            end
        end
        else if (halve) begin
            r = x[8:1];
        end
        else begin
            r = x[7:0];
        end
        pass = (uns && !sub) ? x[8] : !x[9];
        return {pass, r};
    endfunction

    // {pass, result} for one halfword
    function automatic logic [16:0] half_arith(input logic [15:0] a, input logic [15:0] b,
                                               input logic sub, input logic uns,
                                               input logic sat, input logic halve);
        logic signed [17:0] ax;
        logic signed [17:0] bx;
        logic signed [17:0] x;
        logic [15:0]        r;
        logic               pass;
        ax = uns ? $signed({2'b00, a}) : $signed({{2{a[15]}}, a});
        bx = uns ? $signed({2'b00, b}) : $signed({{2{b[15]}}, b});
        x  = sub ? (ax - bx) : (ax + bx);
        if (sat) begin
            if (uns) begin
                r = x[17] ? 16'h0000 : (x[16] ? 16'hffff : x[15:0]);
            end
            else begin
                r = (x < -18'sd32768) ? 16'h8000
                  : ((x > 18'sd32767) ? 16'h7fff : x[15:0]);
            end
        end
        else if (halve) begin
            r = x[16:1];
        end
        else begin
            r = x[15:0];
        end
        pass = (uns && !sub) ? x[16] : !x[17];
        return {pass, r};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/simd_parallel_add_subtract_unit.sv
// An accepted result is registered in out_reg, or in skid_reg if the output stalls.
// Throughput: 1 item per cycle while s_tready is high; the lanes are combinational.
// Two-entry output stage (register plus skid): the skid takes one item in a stall.
// Reset (rst_n low, asynchronous) clears GE flags and both output valids.
// ----------------------------------------------------------------------------
// simd_parallel_add_subtract_unit
// SIMD parallel add/subtract (8/16-bit, signed/unsigned, saturating, halving)
// and SEL, with GE flag state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "simd_parallel_add_subtract_unit_defines.svh"

module simd_parallel_add_subtract_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] first_halfword, [31:16] second_halfword,
    // [63:32] left_operand, [95:64] right_operand
    input  wire logic [95:0] s_tdata,
    // result out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] recognized, [32:1] result_word, [36:33] destination_index,
    // [37] ge_written, [41:38] ge_value, [47:42] zero
    output logic [47:0]      m_tdata
);

    // input fields
    logic [15:0] first_halfword;
    logic [15:0] second_halfword;
    logic [31:0] left_operand;
    logic [31:0] right_operand;

    assign first_halfword  = s_tdata[15:0];
    assign second_halfword = s_tdata[31:16];
    assign left_operand    = s_tdata[63:32];
    assign right_operand   = s_tdata[95:64];

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // ---------------- decode ----------------
    spas_pkg::ctrl_t ctrl;

    spas_decoder u_decoder (
        .first_halfword  (first_halfword),
        .second_halfword (second_halfword),
        .ctrl            (ctrl)
    );

    // ---------------- lanes ----------------
    // ASX/SAX cross the halfwords of the right operand
    logic [15:0] b_lo;
    logic [15:0] b_hi;

    assign b_lo = ctrl.swap ? right_operand[31:16] : right_operand[15:0];
    assign b_hi = ctrl.swap ? right_operand[15:0]  : right_operand[31:16];

    spas_pkg::lane_out_t lane_lo;
    spas_pkg::lane_out_t lane_hi;

    spas_lane u_lane_lo (
        .a        (left_operand[15:0]),
        .b        (b_lo),
        .sub      (ctrl.sub_lo),
        .ctrl     (ctrl),
        .lane_out (lane_lo)
    );

    spas_lane u_lane_hi (
        .a        (left_operand[31:16]),
        .b        (b_hi),
        .sub      (ctrl.sub_hi),
        .ctrl     (ctrl),
        .lane_out (lane_hi)
    );

    // ---------------- merge ----------------
    logic [3:0]        ge_reg;
    logic [3:0]        ge_next;
    spas_pkg::result_t result;

    spas_merge u_merge (
        .ctrl          (ctrl),
        .lane_lo       (lane_lo),
        .lane_hi       (lane_hi),
        .left_operand  (left_operand),
        .right_operand (right_operand),
        .ge_flags      (ge_reg),
        .result        (result)
    );

    // GE flags change only on an accepted plain S/U instruction
    assign ge_next = (s_accept && result.ge_written) ? result.ge_value : ge_reg;

    // ---------------- output stage with skid ----------------
    logic              out_valid_reg;
    logic              out_valid_next;
    spas_pkg::result_t out_reg;
    spas_pkg::result_t out_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    spas_pkg::result_t skid_reg;
    spas_pkg::result_t skid_next;

    assign s_tready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready)
        begin
            // output slot free this cycle: skid drains first
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = s_accept;
                out_next       = result;
            end
        end
        else if (s_accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg         <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            ge_reg         <= ge_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_reg.ge_value, out_reg.ge_written, out_reg.dest,
                       out_reg.word, out_reg.recognized};

    // ---------------- assertions ----------------
    `SPAS_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid full, output empty")
    `SPAS_ASSERT(a_ge_change_cause, !$stable(ge_reg) |-> $past(s_accept && result.ge_written), "GE flags changed without a GE-writing item")
    `SPAS_ASSERT(a_unrecognized_zero, (out_valid_reg && !out_reg.recognized) |-> (out_reg.word == 32'd0 && out_reg.dest == 4'd0 && !out_reg.ge_written), "unrecognized item with nonzero payload")
    `SPAS_NEVER(a_dest_legal, out_valid_reg && out_reg.recognized && (out_reg.dest == spas_pkg::REG_SP || out_reg.dest == spas_pkg::REG_PC), "destination is SP or PC")

endmodule

`default_nettype wire

FILE: rtl/core/spas_decoder.sv
// ----------------------------------------------------------------------------
// spas_decoder
// Decodes the instruction halfwords into lane control.
// ----------------------------------------------------------------------------
`default_nettype none

module spas_decoder (
    input  wire logic [15:0]   first_halfword,
    input  wire logic [15:0]   second_halfword,
    output spas_pkg::ctrl_t    ctrl
);

    logic [3:0] rn;
    logic [3:0] rd;
    logic [3:0] rm;
    logic [2:0] op;
    logic [2:0] mode;
    logic       regs_ok;
    logic       sel_hit;
    logic       par_hit;

    assign rn   = first_halfword[3:0];
    assign rd   = second_halfword[11:8];
    assign rm   = second_halfword[3:0];
    assign op   = first_halfword[6:4];
    assign mode = second_halfword[6:4];

    assign regs_ok = (rn != spas_pkg::REG_SP) && (rn != spas_pkg::REG_PC)
                  && (rd != spas_pkg::REG_SP) && (rd != spas_pkg::REG_PC)
                  && (rm != spas_pkg::REG_SP) && (rm != spas_pkg::REG_PC);

    assign sel_hit = ((first_halfword & spas_pkg::SelMask1) == spas_pkg::SelVal1)
                  && ((second_halfword & spas_pkg::SelMask2) == spas_pkg::SelVal2)
                  && regs_ok;

    assign par_hit = ((first_halfword & spas_pkg::ParMask1) == spas_pkg::ParVal1)
                  && ((second_halfword & spas_pkg::ParMask2) == spas_pkg::ParVal2)
                  && regs_ok && !sel_hit
                  && (op[1:0] != spas_pkg::MK_UNUSED)
                  && (mode[1:0] != spas_pkg::MK_UNUSED);

    always_comb
    begin
        ctrl.sel       = sel_hit;
        ctrl.par       = par_hit;
        ctrl.byte_mode = (op == spas_pkg::OP_ADD8) || (op == spas_pkg::OP_SUB8);
        ctrl.swap      = (op == spas_pkg::OP_ASX) || (op == spas_pkg::OP_SAX);
        // ASX subtracts in the low halfword, SAX in the high one
        ctrl.sub_lo    = (op == spas_pkg::OP_SUB8) || (op == spas_pkg::OP_SUB16)
                      || (op == spas_pkg::OP_ASX);
        ctrl.sub_hi    = (op == spas_pkg::OP_SUB8) || (op == spas_pkg::OP_SUB16)
                      || (op == spas_pkg::OP_SAX);
        ctrl.uns       = mode[2];
        ctrl.sat       = (mode[1:0] == spas_pkg::MK_SAT);
        ctrl.halve     = (mode[1:0] == spas_pkg::MK_HALVE);
        ctrl.rd        = rd;
    end

endmodule

`default_nettype wire

FILE: rtl/core/spas_lane.sv
// ----------------------------------------------------------------------------
// spas_lane
// One 16-bit lane: a halfword or two byte add/subtract ops.
// ----------------------------------------------------------------------------
`default_nettype none

module spas_lane (
    input  wire logic [15:0]     a,
    input  wire logic [15:0]     b,
    input  wire logic            sub,
    input  wire spas_pkg::ctrl_t ctrl,
    output spas_pkg::lane_out_t  lane_out
);

    logic [8:0]  byte0;
    logic [8:0]  byte1;
    logic [16:0] half;

    assign byte0 = spas_pkg::byte_arith(a[7:0], b[7:0], sub, ctrl.uns, ctrl.sat, ctrl.halve);
    assign byte1 = spas_pkg::byte_arith(a[15:8], b[15:8], sub, ctrl.uns, ctrl.sat,
                                        ctrl.halve);
    assign half  = spas_pkg::half_arith(a, b, sub, ctrl.uns, ctrl.sat, ctrl.halve);

    always_comb
    begin
        if (ctrl.byte_mode)
        begin
            lane_out.res = {byte1[7:0], byte0[7:0]};
            lane_out.ge  = {byte1[8], byte0[8]};
        end
        else
        begin
            // halfword GE bits move as a pair
            lane_out.res = half[15:0];
            lane_out.ge  = {half[16], half[16]};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spas_merge.sv
// ----------------------------------------------------------------------------
// spas_merge
// Combines lane results, performs SEL and forms the GE update.
// ----------------------------------------------------------------------------
`default_nettype none

module spas_merge (
    input  wire spas_pkg::ctrl_t     ctrl,
    input  wire spas_pkg::lane_out_t lane_lo,
    input  wire spas_pkg::lane_out_t lane_hi,
    input  wire logic [31:0]         left_operand,
    input  wire logic [31:0]         right_operand,
    input  wire logic [3:0]          ge_flags,
    output spas_pkg::result_t        result
);

    logic [31:0] sel_word;

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            sel_word[n*8 +: 8] = ge_flags[n] ? left_operand[n*8 +: 8]
                                             : right_operand[n*8 +: 8];
        end
    end

    always_comb
    begin
        result.recognized = 1'b0;
        result.word       = '0;
        result.dest       = '0;
        result.ge_written = 1'b0;
        result.ge_value   = ge_flags;
        if (ctrl.sel)
        begin
            result.recognized = 1'b1;
            result.word       = sel_word;
            result.dest       = ctrl.rd;
        end
        else if (ctrl.par)
        begin
            result.recognized = 1'b1;
            result.word       = {lane_hi.res, lane_lo.res};
            result.dest       = ctrl.rd;
            if (!ctrl.sat && !ctrl.halve)
            begin
                result.ge_written = 1'b1;
                result.ge_value   = {lane_hi.ge, lane_lo.ge};
            end
        end
    end

endmodule

`default_nettype wire

FILE: bench/simd_parallel_add_subtract_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_parallel_add_subtract_unit_test
// Streams Thumb-2 parallel add/subtract and SEL items through the unit and
// checks every result item against an in-bench predictor that tracks GE flags.
// ----------------------------------------------------------------------------

module simd_parallel_add_subtract_unit_test;

    localparam int         QuietLimit    = 4000;  // cycles with no handshake at all
    localparam int         LongHold      = 300;   // receiver hold-off, in cycles
    localparam int         PhaseItems    = 550;
    localparam int         EndSettle     = 5;
    // op values with low bits 11 are reserved
    localparam logic [2:0] OP_RSV_LO     = 3'd3;
    localparam logic [2:0] OP_RSV_HI     = 3'd7;
    // mode bit 2
    localparam logic       MODE_SIGNED   = 1'b0;
    localparam logic       MODE_UNSIGNED = 1'b1;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] first_halfword, [31:16] second_halfword,
    // [63:32] left_operand, [95:64] right_operand
    logic [95:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] recognized, [32:1] result_word, [36:33] destination_index,
    // [37] ge_written, [41:38] ge_value, [47:42] zero
    logic [47:0] m_tdata;

    logic [95:0]       items_to_send[$];   // items not yet offered
    spas_pkg::result_t results_due[$];     // predicted results, oldest first
    spas_pkg::result_t oldest_due;
    logic [3:0]        ge_model      = '0; // predictor's copy of the GE flags
    int                send_idle_pct = 30;
    int                recv_idle_pct = 71;
    bit                sender_hold   = 1'b0;
    int                holds_asked   = 0;  // bumped by stimulus, served by receiver
    int                holds_served  = 0;
    int                hold_left     = 0;
    int                quiet_cycles  = 0;
    int                error_count   = 0;

    simd_parallel_add_subtract_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic logic [95:0] par_item(input logic [2:0] op, input logic [2:0] mode,
                                             input logic [3:0] rn, rd, rm,
                                             input logic [31:0] a, b);
        logic [15:0] hw1;
        logic [15:0] hw2;
        hw1 = spas_pkg::ParVal1 | {9'd0, op, rn};
        hw2 = spas_pkg::ParVal2 | {4'd0, rd, 1'b0, mode, rm};
        return {b, a, hw2, hw1};
    endfunction

    function automatic logic [95:0] sel_item(input logic [3:0] rn, rd, rm,
                                             input logic [31:0] a, b);
        logic [15:0] hw1;
        logic [15:0] hw2;
        hw1 = spas_pkg::SelVal1 | {12'd0, rn};
        hw2 = spas_pkg::SelVal2 | {4'd0, rd, 4'd0, rm};
        return {b, a, hw2, hw1};
    endfunction

    // any register but SP and PC
    function automatic logic [3:0] pick_reg();
        logic [3:0] r;
        r = 4'($urandom_range(14));
        if (r == spas_pkg::REG_SP)
            r = 4'($urandom_range(12));
        return r;
    endfunction

    // operands lean on lane corners so saturation and GE boundaries get hit
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        int          j;
        v = $urandom();
        case ($urandom_range(3))
            0:
            begin
                for (j = 0; j < 4; j++)
                begin
                    case ($urandom_range(5))
                        0: v[j*8 +: 8] = 8'h00;
                        1: v[j*8 +: 8] = 8'h01;
                        2: v[j*8 +: 8] = 8'h7f;
                        3: v[j*8 +: 8] = 8'h80;
                        4: v[j*8 +: 8] = 8'hff;
                        default: ;
                    endcase
                end
            end
            1:
            begin
                for (j = 0; j < 2; j++)
                begin
                    case ($urandom_range(5))
                        0: v[j*16 +: 16] = 16'h0000;
                        1: v[j*16 +: 16] = 16'h0001;
                        2: v[j*16 +: 16] = 16'h7fff;
                        3: v[j*16 +: 16] = 16'h8000;
                        4: v[j*16 +: 16] = 16'hffff;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // mostly legal encodings with random content; the rest broken or noise
    function automatic logic [95:0] random_item();
        logic [2:0]  op;
        logic [1:0]  kind;
        logic [2:0]  mode;
        logic [3:0]  rn;
        logic [3:0]  rd;
        logic [3:0]  rm;
        logic [3:0]  bad_reg;
        logic [95:0] item;
        int          pick;
        int          flip_pos;
        case ($urandom_range(5))
            0:       op = spas_pkg::OP_ADD8;
            1:       op = spas_pkg::OP_ADD16;
            2:       op = spas_pkg::OP_ASX;
            3:       op = spas_pkg::OP_SUB8;
            4:       op = spas_pkg::OP_SUB16;
            default: op = spas_pkg::OP_SAX;
        endcase
        case ($urandom_range(2))
            0:       kind = spas_pkg::MK_PLAIN;
            1:       kind = spas_pkg::MK_SAT;
            default: kind = spas_pkg::MK_HALVE;
        endcase
        mode    = {($urandom_range(1) != 0) ? MODE_UNSIGNED : MODE_SIGNED, kind};
        rn      = pick_reg();
        rd      = pick_reg();
        rm      = pick_reg();
        bad_reg = ($urandom_range(1) != 0) ? spas_pkg::REG_SP : spas_pkg::REG_PC;
        pick    = $urandom_range(99);
        if (pick < 66)
        begin
            item = par_item(op, mode, rn, rd, rm, pick_operand(), pick_operand());
        end
        else if (pick < 80)
        begin
            item = sel_item(rn, rd, rm, pick_operand(), pick_operand());
        end
        else if (pick < 90)
        begin
            case ($urandom_range(3))
                0:
                begin
                    op = ($urandom_range(1) != 0) ? OP_RSV_HI : OP_RSV_LO;
                end
                1:
                begin
                    mode[1:0] = spas_pkg::MK_UNUSED;
                end
                2:
                begin
                    case ($urandom_range(2))
                        0:       rn = bad_reg;
                        1:       rd = bad_reg;
                        default: rm = bad_reg;
                    endcase
                end
                default: ;
            endcase
            item = par_item(op, mode, rn, rd, rm, $urandom(), $urandom());
            if ($urandom_range(3) == 0)
                item = sel_item(rn, rd, bad_reg, $urandom(), $urandom());
            // flip one fixed bit of either halfword
            if ($urandom_range(3) == 0)
            begin
                if ($urandom_range(1) != 0)
                    flip_pos = $urandom_range(15, 7);
                else
                    flip_pos = 16 + $urandom_range(15, 12);
                item[flip_pos] = ~item[flip_pos];
            end
        end
        else
        begin
            item = {$urandom(), $urandom(), 16'($urandom()), 16'($urandom())};
        end
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // predictor: one accepted item in, one expected result pushed
    // ------------------------------------------------------------------------
    task automatic predict_simd_result(input logic [95:0] item);
        logic [15:0]       hw1;
        logic [15:0]       hw2;
        logic [31:0]       left;
        logic [31:0]       right;
        logic [31:0]       mask;
        logic [31:0]       word;
        logic [31:0]       ua;
        logic [31:0]       ub;
        logic [31:0]       r;
        logic [3:0]        rn;
        logic [3:0]        rd;
        logic [3:0]        rm;
        logic [3:0]        ge;
        logic [2:0]        op;
        logic [2:0]        mode;
        logic              regs_ok;
        logic              byte_op;
        logic              uns;
        logic              sat;
        logic              halve;
        logic              sub;
        logic              pass;
        int                lane;
        int                w;
        int                lanes;
        int                rl;
        int                a;
        int                b;
        int                x;
        int                half;
        int                full;
        int                lo;
        int                hi;
        spas_pkg::result_t res;
        hw1     = item[15:0];
        hw2     = item[31:16];
        left    = item[63:32];
        right   = item[95:64];
        rn      = hw1[3:0];
        rd      = hw2[11:8];
        rm      = hw2[3:0];
        op      = hw1[6:4];
        mode    = hw2[6:4];
        regs_ok = rn != spas_pkg::REG_SP && rn != spas_pkg::REG_PC
               && rd != spas_pkg::REG_SP && rd != spas_pkg::REG_PC
               && rm != spas_pkg::REG_SP && rm != spas_pkg::REG_PC;
        res     = '0;
        if ((hw1 & spas_pkg::SelMask1) == spas_pkg::SelVal1
            && (hw2 & spas_pkg::SelMask2) == spas_pkg::SelVal2 && regs_ok)
        begin
            // SEL: byte from left where its GE bit is set
            res.recognized = 1'b1;
            res.dest       = rd;
            for (lane = 0; lane < 4; lane++)
                res.word[lane*8 +: 8] = ge_model[lane] ? left[lane*8 +: 8]
                                                       : right[lane*8 +: 8];
        end
        else if ((hw1 & spas_pkg::ParMask1) == spas_pkg::ParVal1
                 && (hw2 & spas_pkg::ParMask2) == spas_pkg::ParVal2 && regs_ok
                 && op != OP_RSV_LO && op != OP_RSV_HI
                 && mode[1:0] != spas_pkg::MK_UNUSED)
        begin
            byte_op = op == spas_pkg::OP_ADD8 || op == spas_pkg::OP_SUB8;
            w       = byte_op ? 8 : 16;
            lanes   = byte_op ? 4 : 2;
            mask    = (32'd1 << w) - 32'd1;
            half    = 1 << (w - 1);
            full    = 1 << w;
            uns     = mode[2];
            sat     = mode[1:0] == spas_pkg::MK_SAT;
            halve   = mode[1:0] == spas_pkg::MK_HALVE;
            word    = '0;
            ge      = '0;
            for (lane = 0; lane < lanes; lane++)
            begin
                rl  = lane;
                sub = op == spas_pkg::OP_SUB8 || op == spas_pkg::OP_SUB16;
                // exchange forms pair each lane with the opposite right halfword
                if (op == spas_pkg::OP_ASX)
                begin
                    rl  = lanes - 1 - lane;
                    sub = lane == 0;
                end
                else if (op == spas_pkg::OP_SAX)
                begin
                    rl  = lanes - 1 - lane;
                    sub = lane != 0;
                end
                ua = (left >> (lane * w)) & mask;
                ub = (right >> (rl * w)) & mask;
                a  = int'(ua);
                b  = int'(ub);
                if (!uns)
                begin
                    if (a >= half)
                        a = a - full;
                    if (b >= half)
                        b = b - full;
                end
                x = sub ? a - b : a + b;
                if (sat)
                begin
                    lo = uns ? 0 : -half;
                    hi = uns ? full - 1 : half - 1;
                    if (x < lo)
                        x = lo;
                    if (x > hi)
                        x = hi;
                    r = x & mask;
                end
                else if (halve)
                begin
                    r = (x >>> 1) & mask;
                end
                else
                begin
                    r    = x & mask;
                    // unsigned add sets GE on carry out, all else on a result >= 0
                    pass = (uns && !sub) ? (x >= full) : (x >= 0);
                    if (pass)
                        ge = ge | (byte_op ? 4'(1 << lane) : 4'(3 << (lane * 2)));
                end
                word = word | (r << (lane * w));
            end
            res.recognized = 1'b1;
            res.word       = word;
            res.dest       = rd;
            if (!sat && !halve)
            begin
                ge_model       = ge;
                res.ge_written = 1'b1;
            end
        end
        res.ge_value = ge_model;
        results_due.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued items, predicts each one at its accepting edge
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            ge_model  = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_simd_result(s_tdata);
            // a new item may go out only once the current one is gone
            if (!s_tvalid || s_tready)
            begin
                if (!sender_hold && items_to_send.size() != 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= items_to_send.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure plus an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            hold_left    <= LongHold;
            m_tready     <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("unexpected result item", m_tdata[32:1], '0);
            end
            else
            begin
                oldest_due = results_due.pop_front();
                check_field("recognized", 32'(m_tdata[0]), 32'(oldest_due.recognized));
                check_field("result_word", m_tdata[32:1], oldest_due.word);
                check_field("destination_index", 32'(m_tdata[36:33]), 32'(oldest_due.dest));
                check_field("ge_written", 32'(m_tdata[37]), 32'(oldest_due.ge_written));
                check_field("ge_value", 32'(m_tdata[41:38]), 32'(oldest_due.ge_value));
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus; all changes land on the falling edge
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        while (s_tvalid || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic drain_queue();
        while (items_to_send.size() != 0)
            @(negedge clk);
        wait_idle();
    endtask

    initial
    begin : stimulus
        int i;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every op, every mode kind, lane extremes
        items_to_send.push_back(par_item(spas_pkg::OP_ADD8, {MODE_SIGNED, spas_pkg::MK_PLAIN},
                                         4'd0, 4'd1, 4'd2, 32'h7f80ff01, 32'h0180ff7f));
        items_to_send.push_back(par_item(spas_pkg::OP_ADD16, {MODE_UNSIGNED, spas_pkg::MK_PLAIN},
                                         4'd14, 4'd14, 4'd14, 32'hffff0001, 32'h0001ffff));
        items_to_send.push_back(par_item(spas_pkg::OP_ASX, {MODE_SIGNED, spas_pkg::MK_PLAIN},
                                         4'd3, 4'd4, 4'd5, 32'h80007fff, 32'h7fff8000));
        items_to_send.push_back(par_item(spas_pkg::OP_SUB8, {MODE_UNSIGNED, spas_pkg::MK_PLAIN},
                                         4'd6, 4'd7, 4'd8, 32'h00ff807f, 32'hff00807f));
        items_to_send.push_back(par_item(spas_pkg::OP_SUB16, {MODE_SIGNED, spas_pkg::MK_SAT},
                                         4'd9, 4'd10, 4'd11, 32'h80007fff, 32'h0001ffff));
        items_to_send.push_back(par_item(spas_pkg::OP_SAX, {MODE_UNSIGNED, spas_pkg::MK_SAT},
                                         4'd12, 4'd0, 4'd1, 32'h0000ffff, 32'h0001ffff));
        items_to_send.push_back(par_item(spas_pkg::OP_ADD8, {MODE_SIGNED, spas_pkg::MK_SAT},
                                         4'd2, 4'd3, 4'd4, 32'h7f807f80, 32'h017fff80));
        items_to_send.push_back(par_item(spas_pkg::OP_ADD16, {MODE_UNSIGNED, spas_pkg::MK_SAT},
                                         4'd5, 4'd6, 4'd7, 32'hffff0000, 32'h00010000));
        items_to_send.push_back(par_item(spas_pkg::OP_SUB8, {MODE_SIGNED, spas_pkg::MK_HALVE},
                                         4'd8, 4'd9, 4'd10, 32'h807f0080, 32'h7f80ff01));
        items_to_send.push_back(par_item(spas_pkg::OP_SUB16, {MODE_UNSIGNED, spas_pkg::MK_HALVE},
                                         4'd11, 4'd12, 4'd14, 32'h0000ffff, 32'hffff0000));
        items_to_send.push_back(par_item(spas_pkg::OP_ASX, {MODE_UNSIGNED, spas_pkg::MK_HALVE},
                                         4'd1, 4'd2, 4'd3, 32'hffffffff, 32'hffffffff));
        items_to_send.push_back(par_item(spas_pkg::OP_SAX, {MODE_SIGNED, spas_pkg::MK_HALVE},
                                         4'd4, 4'd5, 4'd6, 32'h00000000, 32'h00000000));
        // all GE set, then SEL takes every byte from the left
        items_to_send.push_back(par_item(spas_pkg::OP_ADD8, {MODE_UNSIGNED, spas_pkg::MK_PLAIN},
                                         4'd7, 4'd8, 4'd9, 32'hffffffff, 32'h01010101));
        items_to_send.push_back(sel_item(4'd10, 4'd11, 4'd12, 32'h11223344, 32'haabbccdd));
        // low halfword lane passes, high one borrows: GE pair set as a pair
        items_to_send.push_back(par_item(spas_pkg::OP_SUB16, {MODE_UNSIGNED, spas_pkg::MK_PLAIN},
                                         4'd0, 4'd2, 4'd4, 32'h0000ffff, 32'h00010000));
        items_to_send.push_back(sel_item(4'd14, 4'd0, 4'd1, 32'h55667788, 32'h99aabbcc));
        // reserved op and mode
        items_to_send.push_back(par_item(OP_RSV_LO, {MODE_SIGNED, spas_pkg::MK_PLAIN},
                                         4'd1, 4'd2, 4'd3, 32'h12345678, 32'h9abcdef0));
        items_to_send.push_back(par_item(spas_pkg::OP_ADD8, {MODE_UNSIGNED, spas_pkg::MK_UNUSED},
                                         4'd1, 4'd2, 4'd3, 32'hffffffff, 32'h01010101));
        // SP or PC named as a register
        items_to_send.push_back(par_item(spas_pkg::OP_ADD8, {MODE_UNSIGNED, spas_pkg::MK_PLAIN},
                                         spas_pkg::REG_SP, 4'd2, 4'd3, 32'h00000000,
                                         32'h00000000));
        items_to_send.push_back(par_item(spas_pkg::OP_SUB16, {MODE_SIGNED, spas_pkg::MK_PLAIN},
                                         4'd1, spas_pkg::REG_PC, 4'd3, 32'h00000000,
                                         32'h00000000));
        items_to_send.push_back(sel_item(4'd1, 4'd2, spas_pkg::REG_PC, 32'h11111111,
                                         32'h22222222));
        // one fixed bit wrong, in the first halfword and then in the second
        items_to_send.push_back(par_item(spas_pkg::OP_ADD8, {MODE_UNSIGNED, spas_pkg::MK_PLAIN},
                                         4'd1, 4'd2, 4'd3, 32'h00000000, 32'h00000000)
                                ^ (96'd1 << 8));
        items_to_send.push_back(sel_item(4'd1, 4'd2, 4'd3, 32'h11111111, 32'h22222222)
                                ^ (96'd1 << 31));
        items_to_send.push_back('1);
        items_to_send.push_back('0);

        // phase 1: sender idles less than the receiver; one full stop mid-way
        for (i = 0; i < PhaseItems; i++)
            items_to_send.push_back(random_item());
        while (items_to_send.size() > PhaseItems / 2)
            @(negedge clk);
        sender_hold = 1'b1;
        wait_idle();
        sender_hold = 1'b0;
        drain_queue();

        // phase 2: the other way round
        send_idle_pct = 71;
        recv_idle_pct = 30;
        for (i = 0; i < PhaseItems; i++)
            items_to_send.push_back(random_item());
        drain_queue();

        // phase 3: full rate, with a long receiver hold-off that backs up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < PhaseItems; i++)
            items_to_send.push_back(random_item());
        while (items_to_send.size() > PhaseItems - 150)
            @(negedge clk);
        holds_asked = holds_asked + 1;
        drain_queue();

        repeat (EndSettle) @(negedge clk);
        if (results_due.size() != 0)
            report_mismatch("expected results left over", results_due.size(), '0);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
